>>> hw/rtl/wlmb_pkg.sv
// ----------------------------------------------------------------------------
// wlmb_pkg
// Shared types and codes of the window local maxima binner.
// ----------------------------------------------------------------------------
package wlmb_pkg;

    localparam int SAMPLE_W = 16;

    typedef logic [SAMPLE_W-1:0] t_sample;

    // Outcome of binning one point into its cell.
    localparam logic [1:0] ST_STORED    = 2'd0;
    localparam logic [1:0] ST_FIRST_OVF = 2'd1;
    localparam logic [1:0] ST_MORE_OVF  = 2'd2;

    // Commands from the pipeline to the cell binner, acted on at the clock edge.
    typedef struct packed {
        logic lookup;   // capture the count of the cell now presented
        logic clear;    // a new field starts: every cell reads as empty
        logic commit;   // the looked-up point is delivered: update its cell
    } t_bin_ctl;

endpackage

>>> hw/rtl/window_local_maxima_binner.sv
// ----------------------------------------------------------------------------
// window_local_maxima_binner
// Strict local maxima of a raster field over a square window, binned into
// a grid of cells with limited room.
// ----------------------------------------------------------------------------
// Samples of a FIELD_SIDE-square field enter in raster order on the sample
// channel (i_sample_valid / o_sample_ready / i_sample), one per cycle at
// full rate. Each centre of the inner POINTS_SIDE-square area that is
// strictly greater than every other sample of its window gives one request
// on the point channel (o_point_valid / i_point_ready), in raster order,
// with its position, weight, cell, slot and status.
// A sample passes through four register stages: line store read, window
// update, maximum test with cell count lookup, and the output register.
// A point therefore reaches the output through these stages after the sample
// that completes its window is taken, and one sample is taken every cycle
// while the output drains.
// After reset the position counters, the pipeline and all cell counts are
// cleared; no clearing pass is needed. Cell counts clear again when the
// first sample of each field goes through.
// When the receiver stalls, the held request stays in the output register;
// samples keep flowing until a second point would need that register, and
// then o_sample_ready drops until the request is taken.
// ----------------------------------------------------------------------------
module window_local_maxima_binner #(
    parameter int FIELD_SIDE     = 68,
    parameter int POINTS_SIDE    = 64,
    parameter int WINDOW_RADIUS  = 2,
    parameter int CELL_SIDE      = 8,
    parameter int CELL_GRID_SIDE = 8,
    parameter int CELL_ROOM      = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_sample_valid,
    output logic              o_sample_ready,
    input  wlmb_pkg::t_sample i_sample,
    output logic              o_point_valid,
    input  logic              i_point_ready,
    output logic [5:0]        o_point_x,
    output logic [5:0]        o_point_y,
    output logic [15:0]       o_point_weight,
    output logic [5:0]        o_cell_number,
    output logic [2:0]        o_cell_slot,
    output logic [1:0]        o_cell_status
);
    import wlmb_pkg::*;

    localparam int LROWS = 2 * WINDOW_RADIUS;
    localparam int CW    = $clog2(FIELD_SIDE);
    localparam int CXW   = $clog2((FIELD_SIDE - 1) / CELL_SIDE + 2);
    localparam int SW    = $clog2(CELL_SIDE);
    localparam int NCELL = CELL_GRID_SIDE * CELL_GRID_SIDE;
    localparam int CELLW = (CELL_GRID_SIDE > 1) ? $clog2(NCELL) : 1;

    // Position of the next sample, with the cell column and row it maps to.
    logic [CW-1:0]    r_col, r_row;
    logic [CXW-1:0]   r_cx, r_cy;
    logic [SW-1:0]    r_cx_sub, r_cy_sub;
    logic [CW-1:0]    n_col, n_row;
    logic [CXW-1:0]   n_cx, n_cy;
    logic [SW-1:0]    n_cx_sub, n_cy_sub;

    logic             r_a_valid, r_a_cand, r_a_start;
    logic [5:0]       r_a_px, r_a_py;
    logic [CELLW-1:0] r_a_cell_idx;
    logic             r_b_valid, r_b_cand, r_b_start;
    logic [5:0]       r_b_px, r_b_py;
    logic [CELLW-1:0] r_b_cell_idx;
    logic             r_c_found;
    logic [5:0]       r_c_px, r_c_py;
    t_sample          r_c_weight;

    logic             r_out_valid;
    logic [5:0]       r_out_x, r_out_y, r_out_cell;
    t_sample          r_out_weight;
    logic [2:0]       r_out_slot;
    logic [1:0]       r_out_status;

    logic             en, accept, last_col, last_row, cand;
    logic [CELLW-1:0] cell_idx;
    int               cx_sat, cy_sat;
    t_sample          centre;
    logic             is_max;
    t_bin_ctl         bin_ctl;
    logic [CELLW-1:0] bin_cell_idx;
    logic [2:0]       bin_slot;
    logic [1:0]       bin_status;

    // The pipeline moves unless a new point would land on a held request.
    assign en             = !r_out_valid || i_point_ready || !r_c_found;
    assign accept         = i_sample_valid && en;
    assign o_sample_ready = en;

    always_comb begin
        last_col = (r_col == CW'(FIELD_SIDE - 1));
        last_row = (r_row == CW'(FIELD_SIDE - 1));
        n_col    = last_col ? '0 : r_col + CW'(1);
        n_row    = r_row;
        n_cx     = r_cx;
        n_cx_sub = r_cx_sub;
        n_cy     = r_cy;
        n_cy_sub = r_cy_sub;
        if (last_col || int'(r_col) < LROWS) begin
            n_cx     = '0;
            n_cx_sub = '0;
        end else if (int'(r_cx_sub) == CELL_SIDE - 1) begin
            n_cx     = r_cx + CXW'(1);
            n_cx_sub = '0;
        end else begin
            n_cx_sub = r_cx_sub + SW'(1);
        end
        if (last_col) begin
            n_row = last_row ? '0 : r_row + CW'(1);
            if (last_row || int'(r_row) < LROWS) begin
                n_cy     = '0;
                n_cy_sub = '0;
            end else if (int'(r_cy_sub) == CELL_SIDE - 1) begin
                n_cy     = r_cy + CXW'(1);
                n_cy_sub = '0;
            end else begin
                n_cy_sub = r_cy_sub + SW'(1);
            end
        end
    end

    always_comb begin
        cand = (int'(r_col) >= LROWS) && (int'(r_col) < LROWS + POINTS_SIDE)
            && (int'(r_row) >= LROWS) && (int'(r_row) < LROWS + POINTS_SIDE);
        cx_sat   = (int'(r_cx) > CELL_GRID_SIDE - 1) ? CELL_GRID_SIDE - 1 : int'(r_cx);
        cy_sat   = (int'(r_cy) > CELL_GRID_SIDE - 1) ? CELL_GRID_SIDE - 1 : int'(r_cy);
        cell_idx = CELLW'(cy_sat * CELL_GRID_SIDE + cx_sat);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col    <= '0;
            r_row    <= '0;
            r_cx     <= '0;
            r_cy     <= '0;
            r_cx_sub <= '0;
            r_cy_sub <= '0;
        end else if (accept) begin
            r_col    <= n_col;
            r_row    <= n_row;
            r_cx     <= n_cx;
            r_cy     <= n_cy;
            r_cx_sub <= n_cx_sub;
            r_cy_sub <= n_cy_sub;
        end
    end

    // Stage valids.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_c_found <= 1'b0;
        end else if (en) begin
            r_a_valid <= accept;
            r_b_valid <= r_a_valid;
            r_c_found <= r_b_valid && r_b_cand && is_max;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            if (accept) begin
                r_a_cand     <= cand;
                r_a_start    <= (r_col == '0) && (r_row == '0);
                r_a_px       <= 6'(r_col - CW'(LROWS));
                r_a_py       <= 6'(r_row - CW'(LROWS));
                r_a_cell_idx <= cell_idx;
            end
            r_b_cand     <= r_a_cand;
            r_b_start    <= r_a_start;
            r_b_px       <= r_a_px;
            r_b_py       <= r_a_py;
            r_b_cell_idx <= r_a_cell_idx;
            r_c_px       <= r_b_px;
            r_c_py       <= r_b_py;
            r_c_weight   <= centre;
        end
    end

    wlmb_window #(
        .FIELD_SIDE    (FIELD_SIDE),
        .WINDOW_RADIUS (WINDOW_RADIUS)
    ) u_window (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (en),
        .i_accept (accept),
        .i_sample (i_sample),
        .i_col    (r_col),
        .o_centre (centre),
        .o_is_max (is_max)
    );

    always_comb begin
        bin_ctl.lookup = en;
        bin_ctl.clear  = en && r_b_valid && r_b_start;
        bin_ctl.commit = en && r_c_found;
    end

    wlmb_binner #(
        .CELL_GRID_SIDE (CELL_GRID_SIDE),
        .CELL_ROOM      (CELL_ROOM)
    ) u_binner (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (bin_ctl),
        .i_cell_idx (r_b_cell_idx),
        .o_cell_idx (bin_cell_idx),
        .o_slot     (bin_slot),
        .o_status   (bin_status)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (!r_out_valid || i_point_ready) begin
            r_out_valid <= r_c_found;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_c_found && (!r_out_valid || i_point_ready)) begin
            r_out_x      <= r_c_px;
            r_out_y      <= r_c_py;
            r_out_weight <= r_c_weight;
            r_out_cell   <= 6'(bin_cell_idx);
            r_out_slot   <= bin_slot;
            r_out_status <= bin_status;
        end
    end

    assign o_point_valid  = r_out_valid;
    assign o_point_x      = r_out_x;
    assign o_point_y      = r_out_y;
    assign o_point_weight = r_out_weight;
    assign o_cell_number  = r_out_cell;
    assign o_cell_slot    = r_out_slot;
    assign o_cell_status  = r_out_status;

endmodule

>>> hw/rtl/wlmb_window.sv
// ----------------------------------------------------------------------------
// wlmb_window
// Line store and square window registers with the strict maximum test on
// the window centre.
// ----------------------------------------------------------------------------
module wlmb_window #(
    parameter int FIELD_SIDE    = 68,
    parameter int WINDOW_RADIUS = 2
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic                          i_accept,
    input  wlmb_pkg::t_sample             i_sample,
    input  logic [$clog2(FIELD_SIDE)-1:0] i_col,
    output wlmb_pkg::t_sample             o_centre,
    output logic                          o_is_max
);
    import wlmb_pkg::*;

    localparam int SPAN  = 2 * WINDOW_RADIUS + 1;
    localparam int LROWS = 2 * WINDOW_RADIUS;
    localparam int CW    = $clog2(FIELD_SIDE);
    localparam int WORDW = LROWS * SAMPLE_W;

    // One word per column holds the stored rows of that column, oldest first.
    logic [WORDW-1:0] r_mem [FIELD_SIDE];
    logic [WORDW-1:0] r_rd;
    t_sample          r_smp;
    logic [CW-1:0]    r_col;
    logic             r_full;
    t_sample          r_win [SPAN][SPAN];

    t_sample          col_new [SPAN];
    logic [WORDW-1:0] wr_word;

    always_comb begin
        for (int k = 0; k < LROWS; k++) begin
            col_new[k] = r_rd[k*SAMPLE_W +: SAMPLE_W];
        end
        col_new[LROWS] = r_smp;
        for (int k = 0; k < LROWS; k++) begin
            wr_word[k*SAMPLE_W +: SAMPLE_W] = col_new[k+1];
        end
    end

    // The write goes to the column of the previous sample while the read
    // fetches the next column, so the two addresses never coincide.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_accept) begin
                r_rd  <= r_mem[i_col];
                r_smp <= i_sample;
                r_col <= i_col;
            end
            if (r_full) begin
                r_mem[r_col] <= wr_word;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_full <= 1'b0;
        end else if (i_en) begin
            r_full <= i_accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int dy = 0; dy < SPAN; dy++) begin
                for (int dx = 0; dx < SPAN; dx++) begin
                    r_win[dy][dx] <= '0;
                end
            end
        end else if (i_en && r_full) begin
            for (int dy = 0; dy < SPAN; dy++) begin
                for (int dx = 0; dx < SPAN - 1; dx++) begin
                    r_win[dy][dx] <= r_win[dy][dx+1];
                end
                r_win[dy][SPAN-1] <= col_new[dy];
            end
        end
    end

    assign o_centre = r_win[WINDOW_RADIUS][WINDOW_RADIUS];

    always_comb begin
        o_is_max = 1'b1;
        for (int dy = 0; dy < SPAN; dy++) begin
            for (int dx = 0; dx < SPAN; dx++) begin
                if (!(dy == WINDOW_RADIUS && dx == WINDOW_RADIUS)) begin
                    if (!(o_centre > r_win[dy][dx])) begin
                        o_is_max = 1'b0;
                    end
                end
            end
        end
    end

endmodule

>>> hw/rtl/wlmb_binner.sv
// ----------------------------------------------------------------------------
// wlmb_binner
// Per-cell point counts: slot assignment and overflow reporting.
// ----------------------------------------------------------------------------
module wlmb_binner #(
    parameter int CELL_GRID_SIDE = 8,
    parameter int CELL_ROOM      = 8
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  wlmb_pkg::t_bin_ctl   i_ctl,
    input  logic [((CELL_GRID_SIDE > 1) ? $clog2(CELL_GRID_SIDE*CELL_GRID_SIDE) : 1)-1:0]
                                 i_cell_idx,
    output logic [((CELL_GRID_SIDE > 1) ? $clog2(CELL_GRID_SIDE*CELL_GRID_SIDE) : 1)-1:0]
                                 o_cell_idx,
    output logic [2:0]           o_slot,
    output logic [1:0]           o_status
);
    import wlmb_pkg::*;

    localparam int NCELL = CELL_GRID_SIDE * CELL_GRID_SIDE;
    localparam int CELLW = (CELL_GRID_SIDE > 1) ? $clog2(NCELL) : 1;
    localparam int FW    = $clog2(CELL_ROOM + 2);

    logic [FW-1:0]    r_mem [NCELL];
    logic [NCELL-1:0] r_vld;
    logic [FW-1:0]    r_rd;
    logic             r_rd_vld;
    logic [CELLW-1:0] r_cell_idx;

    logic [FW-1:0]    count;
    logic             wr_en;

    always_comb begin
        count = r_rd_vld ? r_rd : '0;
        wr_en = i_ctl.commit && (int'(count) <= CELL_ROOM);
        o_slot = 3'd0;
        if (int'(count) < CELL_ROOM) begin
            o_status = ST_STORED;
            o_slot   = 3'(count);
        end else if (int'(count) == CELL_ROOM) begin
            o_status = ST_FIRST_OVF;
        end else begin
            o_status = ST_MORE_OVF;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.lookup) begin
            r_rd       <= r_mem[i_cell_idx];
            r_rd_vld   <= r_vld[i_cell_idx];
            r_cell_idx <= i_cell_idx;
        end
        if (wr_en) begin
            r_mem[r_cell_idx] <= count + FW'(1);
        end
    end

    // A field start empties every cell; it wins over a point of the old
    // field that is committed at the same edge.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_ctl.clear) begin
            r_vld <= '0;
        end else if (wr_en) begin
            r_vld[r_cell_idx] <= 1'b1;
        end
    end

    assign o_cell_idx = r_cell_idx;

endmodule

>>> hw/rtl/wlmb_checker.sv
// ----------------------------------------------------------------------------
// wlmb_checker
// Port-level checks of the window local maxima binner, bound to the top.
// ----------------------------------------------------------------------------
module wlmb_checker (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_sample_valid,
    input logic              o_sample_ready,
    input wlmb_pkg::t_sample i_sample,
    input logic              o_point_valid,
    input logic              i_point_ready,
    input logic [5:0]        o_point_x,
    input logic [5:0]        o_point_y,
    input logic [15:0]       o_point_weight,
    input logic [5:0]        o_cell_number,
    input logic [2:0]        o_cell_slot,
    input logic [1:0]        o_cell_status
);
    import wlmb_pkg::*;

    // A held request keeps its whole payload until it is taken.
    a_point_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_point_valid && !i_point_ready |=> o_point_valid
            && $stable(o_point_x) && $stable(o_point_y) && $stable(o_point_weight)
            && $stable(o_cell_number) && $stable(o_cell_slot) && $stable(o_cell_status))
        else $error("point request changed while stalled");

    // Input is only refused while a request is waiting at the output.
    a_ready_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_sample_ready |-> o_point_valid && !i_point_ready)
        else $error("sample refused without a stalled point request");

    // A point that is not stored carries slot zero.
    a_ovf_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_point_valid && o_cell_status != ST_STORED |-> o_cell_slot == 3'd0)
        else $error("overflow point with non-zero slot");

    // Reset empties the output register.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_point_valid)
        else $error("point request present after reset");

endmodule

bind window_local_maxima_binner wlmb_checker u_wlmb_checker (.*);

>>> tb/window_local_maxima_binner_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// window_local_maxima_binner_tb
// Self-checking bench for the 5x5 strict local maxima finder and cell binner.
// ----------------------------------------------------------------------------
// A short table of extreme samples opens the first field. Patterned content
// follows at random: dense lattices of peaks that overfill cells, full-range
// noise, low-valued plateaus full of ties, and sparse spikes. The run covers
// the top rows of a field, enough for the first cells to overflow. Every
// point request is checked against a predictor kept in this bench. Both
// sides idle at random in three mixes, and once the receiver holds off for
// a long stretch so that the block backs up onto its input.
// ----------------------------------------------------------------------------
module window_local_maxima_binner_tb;
    import wlmb_pkg::*;

    localparam int FIELD_SIDE     = 68;
    localparam int POINTS_SIDE    = 64;
    localparam int WINDOW_RADIUS  = 2;
    localparam int CELL_SIDE      = 8;
    localparam int CELL_GRID_SIDE = 8;
    localparam int CELL_ROOM      = 8;

    localparam int WIN_SPAN   = 2 * WINDOW_RADIUS + 1;
    localparam int LINE_ROWS  = 2 * WINDOW_RADIUS;
    localparam int CELL_TOTAL = CELL_GRID_SIDE * CELL_GRID_SIDE;

    localparam int     OPENING_ROWS      = 25;
    localparam int     RANDOM_ITEMS      = 1275;
    localparam int     LONG_STALL_AT     = 1000;
    localparam int     LONG_STALL_CYCLES = 400;
    localparam int     DRAIN_CYCLES      = 16;
    localparam int     DRAIN_LIMIT       = 20000;
    localparam int     PRINT_LIMIT       = 50;
    localparam longint TIMEOUT_NS        = 2_000_000;

    // Peaks of a lattice sit three apart, just clear of each other's window,
    // and carry the top bit so that they beat every background sample.
    localparam int      LATTICE_PITCH = 3;
    localparam t_sample LATTICE_BIT   = 16'h8000;

    typedef struct packed {
        logic [5:0] x;
        logic [5:0] y;
        t_sample    weight;
        logic [5:0] cell_no;
        logic [2:0] slot;
        logic [1:0] status;
    } t_point;

    typedef struct packed {
        t_sample value;
        logic    typed;
        logic    yields;
        t_point  point;
    } t_opening_row;

    typedef enum logic [1:0] {
        PAT_LATTICE,
        PAT_NOISE,
        PAT_TIES,
        PAT_SPARSE
    } t_pattern;

    logic       i_clk = 1'b0;
    logic       i_rst_n;
    logic       i_sample_valid;
    logic       o_sample_ready;
    t_sample    i_sample;
    logic       o_point_valid;
    logic       i_point_ready;
    logic [5:0] o_point_x;
    logic [5:0] o_point_y;
    t_sample    o_point_weight;
    logic [5:0] o_cell_number;
    logic [2:0] o_cell_slot;
    logic [1:0] o_cell_status;

    window_local_maxima_binner #(
        .FIELD_SIDE     (FIELD_SIDE),
        .POINTS_SIDE    (POINTS_SIDE),
        .WINDOW_RADIUS  (WINDOW_RADIUS),
        .CELL_SIDE      (CELL_SIDE),
        .CELL_GRID_SIDE (CELL_GRID_SIDE),
        .CELL_ROOM      (CELL_ROOM)
    ) u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_sample_valid (i_sample_valid),
        .o_sample_ready (o_sample_ready),
        .i_sample       (i_sample),
        .o_point_valid  (o_point_valid),
        .i_point_ready  (i_point_ready),
        .o_point_x      (o_point_x),
        .o_point_y      (o_point_y),
        .o_point_weight (o_point_weight),
        .o_cell_number  (o_cell_number),
        .o_cell_slot    (o_cell_slot),
        .o_cell_status  (o_cell_status)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Predictor state.
    t_sample    line_rows [LINE_ROWS][FIELD_SIDE];
    t_sample    win [WIN_SPAN][WIN_SPAN];
    int         pred_col;
    int         pred_row;
    logic [3:0] fill_count [CELL_TOTAL];

    t_point   pending_points [$];
    t_pattern cell_pattern [CELL_TOTAL];

    int tx_col;
    int tx_row;
    int tx_idle_pct;
    int rx_idle_pct;
    bit long_stall_pending;
    int err_count;
    int samples_sent;
    int fields_started;
    int points_checked;
    int overflows_seen;

    // Row zero of a field holds no candidate, so none of these samples may
    // raise a point; they still feed the windows of the first candidate row.
    t_opening_row opening_rows [OPENING_ROWS] = '{
        '{16'h0000, 1'b1, 1'b0, '0},
        '{16'hFFFF, 1'b1, 1'b0, '0},
        '{16'h8000, 1'b1, 1'b0, '0},
        '{16'h7FFF, 1'b1, 1'b0, '0},
        '{16'h0001, 1'b1, 1'b0, '0},
        '{16'hFFFE, 1'b1, 1'b0, '0},
        '{16'hAAAA, 1'b1, 1'b0, '0},
        '{16'h5555, 1'b1, 1'b0, '0},
        '{16'h00FF, 1'b1, 1'b0, '0},
        '{16'hFF00, 1'b1, 1'b0, '0},
        '{16'h0F0F, 1'b1, 1'b0, '0},
        '{16'hF0F0, 1'b1, 1'b0, '0},
        '{16'h8001, 1'b1, 1'b0, '0},
        '{16'h7FFE, 1'b1, 1'b0, '0},
        '{16'hFFFF, 1'b1, 1'b0, '0},
        '{16'hFFFF, 1'b1, 1'b0, '0},
        '{16'h0000, 1'b1, 1'b0, '0},
        '{16'h0000, 1'b1, 1'b0, '0},
        '{16'h1234, 1'b1, 1'b0, '0},
        '{16'hEDCB, 1'b1, 1'b0, '0},
        '{16'h3333, 1'b1, 1'b0, '0},
        '{16'hCCCC, 1'b1, 1'b0, '0},
        '{16'h0002, 1'b1, 1'b0, '0},
        '{16'h4000, 1'b1, 1'b0, '0},
        '{16'hBFFF, 1'b1, 1'b0, '0}
    };

    task automatic flag_mismatch(input string msg);
        if (err_count < PRINT_LIMIT) begin
            $display("MISMATCH: %s", msg);
        end
        err_count++;
    endtask

    // Advances the window by one sample and tells whether its centre is a
    // strict maximum, with the point and the binning it gets.
    function automatic bit predict_maximum(input t_sample s, output t_point p);
        t_sample column [WIN_SPAN];
        t_sample centre;
        int      c;
        int      r;
        int      px;
        int      py;
        int      cx;
        int      cy;
        int      cell_no;
        bit      is_max;
        c = pred_col;
        r = pred_row;
        p = '0;
        if (c == 0 && r == 0) begin
            foreach (fill_count[i]) fill_count[i] = '0;
        end
        for (int k = 0; k < LINE_ROWS; k++) column[k] = line_rows[k][c];
        column[LINE_ROWS] = s;
        for (int k = 0; k < LINE_ROWS; k++) line_rows[k][c] = column[k + 1];
        for (int dy = 0; dy < WIN_SPAN; dy++) begin
            for (int dx = 0; dx < WIN_SPAN - 1; dx++) win[dy][dx] = win[dy][dx + 1];
            win[dy][WIN_SPAN - 1] = column[dy];
        end
        centre = win[WINDOW_RADIUS][WINDOW_RADIUS];
        is_max = (c >= LINE_ROWS) && (r >= LINE_ROWS) &&
                 (c - LINE_ROWS < POINTS_SIDE) && (r - LINE_ROWS < POINTS_SIDE);
        for (int dy = 0; dy < WIN_SPAN; dy++) begin
            for (int dx = 0; dx < WIN_SPAN; dx++) begin
                if (!(dy == WINDOW_RADIUS && dx == WINDOW_RADIUS) && centre <= win[dy][dx]) begin
                    is_max = 1'b0;
                end
            end
        end
        if (is_max) begin
            px = c - LINE_ROWS;
            py = r - LINE_ROWS;
            cx = px / CELL_SIDE;
            cy = py / CELL_SIDE;
            if (cx > CELL_GRID_SIDE - 1) cx = CELL_GRID_SIDE - 1;
            if (cy > CELL_GRID_SIDE - 1) cy = CELL_GRID_SIDE - 1;
            cell_no  = cy * CELL_GRID_SIDE + cx;
            p.x      = px[5:0];
            p.y      = py[5:0];
            p.weight = centre;
            p.cell_no = cell_no[5:0];
            if (fill_count[cell_no] < CELL_ROOM) begin
                p.slot   = fill_count[cell_no][2:0];
                p.status = ST_STORED;
                fill_count[cell_no]++;
            end else if (fill_count[cell_no] == CELL_ROOM) begin
                p.status = ST_FIRST_OVF;
                fill_count[cell_no]++;
            end else begin
                p.status = ST_MORE_OVF;
            end
        end
        c++;
        if (c >= FIELD_SIDE) begin
            c = 0;
            r++;
            if (r >= FIELD_SIDE) r = 0;
        end
        pred_col = c;
        pred_row = r;
        return is_max;
    endfunction

    // Picks a content pattern for every cell of the coming field. The first
    // cell is always a lattice, so that it can overflow in every field.
    function automatic void plan_field();
        int roll;
        foreach (cell_pattern[i]) begin
            roll = $urandom_range(99);
            if (roll < 50) cell_pattern[i] = PAT_LATTICE;
            else if (roll < 70) cell_pattern[i] = PAT_NOISE;
            else if (roll < 85) cell_pattern[i] = PAT_TIES;
            else cell_pattern[i] = PAT_SPARSE;
        end
        cell_pattern[0] = PAT_LATTICE;
    endfunction

    function automatic t_sample field_sample(input int r, input int c);
        int  px;
        int  py;
        int  cx;
        int  cy;
        bit  on_lattice;
        px = c - WINDOW_RADIUS;
        py = r - WINDOW_RADIUS;
        on_lattice = (px >= 0) && (py >= 0) &&
                     (px % LATTICE_PITCH == 0) && (py % LATTICE_PITCH == 0);
        if (px < 0) px = 0;
        if (py < 0) py = 0;
        cx = px / CELL_SIDE;
        cy = py / CELL_SIDE;
        if (cx > CELL_GRID_SIDE - 1) cx = CELL_GRID_SIDE - 1;
        if (cy > CELL_GRID_SIDE - 1) cy = CELL_GRID_SIDE - 1;
        case (cell_pattern[cy * CELL_GRID_SIDE + cx])
            PAT_LATTICE: begin
                if (on_lattice) return LATTICE_BIT | t_sample'($urandom_range(0, 16'h7FFF));
                return t_sample'($urandom_range(0, 16'h7FFF));
            end
            PAT_NOISE: return t_sample'($urandom());
            PAT_TIES:  return t_sample'($urandom_range(0, 3));
            default: begin
                if ($urandom_range(19) != 0) return 16'h0000;
                if ($urandom_range(1) != 0) return 16'hFFFF;
                return t_sample'($urandom());
            end
        endcase
    endfunction

    // Offers one sample, runs the predictor once it is taken and queues
    // what the block must answer.
    task automatic take_sample(input t_sample value, input bit typed, input bit yields,
                               input t_point typed_point);
        t_point predicted;
        bit     found;
        if (tx_col == 0 && tx_row == 0) fields_started++;
        while ($urandom_range(99) < tx_idle_pct) begin
            i_sample_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_sample_valid <= 1'b1;
        i_sample       <= value;
        do @(posedge i_clk); while (!o_sample_ready);
        found = predict_maximum(value, predicted);
        if (typed) begin
            if (yields) pending_points = {pending_points, typed_point};
        end else if (found) begin
            pending_points = {pending_points, predicted};
        end
        samples_sent++;
        tx_col++;
        if (tx_col >= FIELD_SIDE) begin
            tx_col = 0;
            tx_row++;
            if (tx_row >= FIELD_SIDE) tx_row = 0;
        end
    endtask

    // Receiver. A long hold-off is counted out here while the sender keeps
    // offering, so that the block fills and stalls its input.
    initial begin
        i_point_ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (long_stall_pending) begin
                long_stall_pending = 1'b0;
                repeat (LONG_STALL_CYCLES) begin
                    i_point_ready <= 1'b0;
                    @(posedge i_clk);
                end
            end
            i_point_ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // Each accepted point request is compared with the oldest expectation.
    always @(posedge i_clk) begin
        t_point got;
        t_point want;
        if (i_rst_n && o_point_valid && i_point_ready) begin
            got = '{o_point_x, o_point_y, o_point_weight, o_cell_number,
                    o_cell_slot, o_cell_status};
            if (pending_points.size() == 0) begin
                flag_mismatch($sformatf("unexpected point x=%0d y=%0d weight=%h",
                                        got.x, got.y, got.weight));
            end else begin
                want = pending_points.pop_front();
                if (got.x !== want.x)
                    flag_mismatch($sformatf("point %0d: x got %0d want %0d",
                                            points_checked, got.x, want.x));
                if (got.y !== want.y)
                    flag_mismatch($sformatf("point %0d: y got %0d want %0d",
                                            points_checked, got.y, want.y));
                if (got.weight !== want.weight)
                    flag_mismatch($sformatf("point %0d: weight got %h want %h",
                                            points_checked, got.weight, want.weight));
                if (got.cell_no !== want.cell_no)
                    flag_mismatch($sformatf("point %0d: cell got %0d want %0d",
                                            points_checked, got.cell_no, want.cell_no));
                if (got.slot !== want.slot)
                    flag_mismatch($sformatf("point %0d: slot got %0d want %0d",
                                            points_checked, got.slot, want.slot));
                if (got.status !== want.status)
                    flag_mismatch($sformatf("point %0d: status got %0d want %0d",
                                            points_checked, got.status, want.status));
                if (want.status == ST_FIRST_OVF) overflows_seen++;
            end
            points_checked++;
        end
    end

    initial begin
        #(TIMEOUT_NS);
        $display("Simulation FAILED");
        $finish;
    end

    initial begin
        int waited;
        i_rst_n        = 1'b0;
        i_sample_valid = 1'b0;
        i_sample       = '0;
        long_stall_pending = 1'b0;
        tx_col = 0;
        tx_row = 0;
        pred_col = 0;
        pred_row = 0;
        err_count = 0;
        samples_sent = 0;
        fields_started = 0;
        points_checked = 0;
        overflows_seen = 0;
        foreach (line_rows[k, c]) line_rows[k][c] = '0;
        foreach (win[dy, dx]) win[dy][dx] = '0;
        foreach (fill_count[i]) fill_count[i] = '0;
        foreach (cell_pattern[i]) cell_pattern[i] = PAT_NOISE;
        tx_idle_pct = 6;
        rx_idle_pct = 78;

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (opening_rows[i]) begin
            take_sample(opening_rows[i].value, opening_rows[i].typed,
                        opening_rows[i].yields, opening_rows[i].point);
        end

        for (int idx = 0; idx < RANDOM_ITEMS; idx++) begin
            case ((idx * 3) / RANDOM_ITEMS)
                0: begin
                    tx_idle_pct = 6;
                    rx_idle_pct = 78;
                end
                1: begin
                    tx_idle_pct = 78;
                    rx_idle_pct = 6;
                end
                default: begin
                    tx_idle_pct = 0;
                    rx_idle_pct = 0;
                end
            endcase
            if (idx == LONG_STALL_AT) long_stall_pending = 1'b1;
            if (idx == 0 || (tx_col == 0 && tx_row == 0)) plan_field();
            take_sample(field_sample(tx_row, tx_col), 1'b0, 1'b0, '0);
        end
        i_sample_valid <= 1'b0;

        waited = 0;
        while (pending_points.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (pending_points.size() != 0) begin
            flag_mismatch($sformatf("%0d expected points never arrived",
                                    pending_points.size()));
        end

        $display("Run covered %0d samples over %0d field starts and %0d point requests,",
                 samples_sent, fields_started, points_checked);
        $display("%0d of them first cell overflows, under three idle mixes and one hold-off.",
                 overflows_seen);
        if (err_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
